// File: rtl/sbm_pkg.sv
`default_nettype none

package sbm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 16;
    localparam int SUM_W    = 18;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PCT_W    = 7;
    localparam int TOTAL_W  = 32;
    localparam int QX_W     = 16;
    localparam int K_W      = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOLAR        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP         = 3'd6;

    localparam logic [CFG_W-1:0] RST_PANEL_GAIN   = 16'd6600;
    localparam logic [CFG_W-1:0] RST_BATTERY_GAIN = 16'd6600;
    localparam logic [CFG_W-1:0] RST_FULL         = 16'd4200;
    localparam logic [CFG_W-1:0] RST_EMPTY        = 16'd3000;
    localparam logic [CFG_W-1:0] RST_LOW          = 16'd3300;
    localparam logic [CFG_W-1:0] RST_SOLAR        = 16'd5000;
    localparam logic [CFG_W-1:0] RST_STEP         = 16'd56;

    // Power source codes
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_SOLAR   = 2'd1;
    localparam logic [1:0] SRC_BATTERY = 2'd2;

    localparam logic [MV_W:0]    CHARGE_MARGIN_MV = 17'd300;
    localparam logic [PCT_W-1:0] PCT_FULL         = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY        = 7'd0;
    // 1.3 scaled by 100 and by 2^16
    localparam logic [K_W-1:0]   K_BASE           = 24'd8519680;

    typedef struct packed {
        logic [SAMPLE_W-1:0] panel_sample;
        logic [SAMPLE_W-1:0] battery_sample;
    } in_item_t;

    typedef struct packed {
        logic [MV_W-1:0]    panel_mv;
        logic [MV_W-1:0]    battery_mv;
        logic [PCT_W-1:0]   charge_percent;
        logic               battery_low;
        logic [1:0]         power_source;
        logic               charging;
        logic [TOTAL_W-1:0] charge_uah;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/solar_battery_monitor.sv
// Averaging voltage monitor for a solar-charged battery.
//
// Input channel (in_valid/in_ready/in_data) takes one pair of 12-bit panel and
// battery converter samples per transfer. Output channel (out_valid/out_ready/
// out_data) delivers one reading after every SAMPLES_PER_READING pairs.
// The configuration port (cfg_we/cfg_index/cfg_data) writes one of the seven 16-bit
// registers per write; it should only be used while no reading is in flight.
//
// A pair that does not complete a reading is only added to the sums. The pair that
// completes a reading starts a bit-serial sequence: shift-add multiplication for
// both millivolt conversions, a preparation step, then, when the battery lies
// strictly between empty and full, restoring division, a step to form the fit
// coefficient and shift-add multiplication for the quadratic. No pair is taken
// until the result has been placed in the output register.
// The output register holds a finished reading while the receiver stalls; new
// pairs are still taken, and a following reading waits at its end for the slot.
// Reset clears the sums, pair count and charge total and reloads the registers.
`default_nettype none

module solar_battery_monitor
    import sbm_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam logic [6:0] LAST_PAIR = 7'(SAMPLES_PER_READING - 1);
    localparam int MUL_W = SUM_W + CFG_W;
    localparam int SQ_W  = K_W + QX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_PREP,
        ST_DIV,
        ST_KPREP,
        ST_SQ,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] panel_gain_reg, panel_gain_next;
    logic [CFG_W-1:0] battery_gain_reg, battery_gain_next;
    logic [CFG_W-1:0] full_reg, full_next;
    logic [CFG_W-1:0] empty_reg, empty_next;
    logic [CFG_W-1:0] low_reg, low_next;
    logic [CFG_W-1:0] solar_reg, solar_next;
    logic [CFG_W-1:0] step_reg, step_next;

    logic [5:0]         pair_count_reg, pair_count_next;
    logic [SUM_W-1:0]   panel_sum_reg, panel_sum_next;
    logic [SUM_W-1:0]   battery_sum_reg, battery_sum_next;
    logic [TOTAL_W-1:0] charge_total_reg, charge_total_next;
    logic [3:0]         step_cnt_reg, step_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath registers
    logic [SUM_W-1:0] psum_op_reg, psum_op_next;
    logic [SUM_W-1:0] bsum_op_reg, bsum_op_next;
    logic [MUL_W-1:0] pmul_reg, pmul_next;
    logic [MUL_W-1:0] bmul_reg, bmul_next;
    logic [MV_W-1:0]  pmv_reg, pmv_next;
    logic [MV_W-1:0]  bmv_reg, bmv_next;
    logic             ge_full_reg, ge_full_next;
    logic             le_empty_reg, le_empty_next;
    logic [MV_W-1:0]  rem_reg, rem_next;
    logic [MV_W-1:0]  divisor_reg, divisor_next;
    logic [QX_W-1:0]  quot_reg, quot_next;
    logic [K_W-1:0]   coef_reg, coef_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    out_item_t        out_data_reg, out_data_next;

    logic             in_fire;
    logic [SUM_W-1:0] psum_add;
    logic [SUM_W-1:0] bsum_add;
    logic [SUM_W:0]   pmul_part;
    logic [SUM_W:0]   bmul_part;
    logic [MV_W-1:0]  pmv_sat;
    logic [MV_W-1:0]  bmv_sat;
    logic [MV_W:0]    rem_shift;
    logic [K_W:0]     sq_part;
    logic [K_W-1:0]   quot_x30;
    logic [7:0]       pct_raw;
    logic [PCT_W-1:0] pct;
    logic             src_solar;
    logic             src_battery;
    logic             charging;
    logic [1:0]       source;
    logic [TOTAL_W:0] total_add;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;

    assign psum_add = panel_sum_reg + SUM_W'(in_data.panel_sample);
    assign bsum_add = battery_sum_reg + SUM_W'(in_data.battery_sample);

    // Shift-add step: the multiplier sits in the low half and shifts out LSB first.
    assign pmul_part = {1'b0, pmul_reg[MUL_W-1:CFG_W]} + (pmul_reg[0] ? {1'b0, psum_op_reg} : '0);
    assign bmul_part = {1'b0, bmul_reg[MUL_W-1:CFG_W]} + (bmul_reg[0] ? {1'b0, bsum_op_reg} : '0);

    assign pmv_sat = (pmul_reg[MUL_W-1:MUL_W-2] != 2'b00) ? '1 : pmul_reg[MUL_W-3:CFG_W];
    assign bmv_sat = (bmul_reg[MUL_W-1:MUL_W-2] != 2'b00) ? '1 : bmul_reg[MUL_W-3:CFG_W];

    assign rem_shift = {rem_reg, 1'b0};
    assign quot_x30  = K_W'({quot_reg, 5'b0}) - K_W'({quot_reg, 1'b0});
    assign sq_part   = {1'b0, sq_reg[SQ_W-1:QX_W]} + (sq_reg[0] ? {1'b0, coef_reg} : '0);

    assign pct_raw = sq_reg[SQ_W-1:SQ_W-8];

    always_comb
    begin
        if (ge_full_reg)
            pct = PCT_FULL;
        else if (le_empty_reg)
            pct = PCT_EMPTY;
        else if (pct_raw > 8'(PCT_FULL))
            pct = PCT_FULL;
        else
            pct = pct_raw[PCT_W-1:0];
    end

    // Source decision on the finished reading.
    assign src_solar   = pmv_reg > solar_reg;
    assign src_battery = !src_solar && (bmv_reg > empty_reg);
    assign charging    = src_solar ||
                         (src_battery && ({1'b0, pmv_reg} > ({1'b0, bmv_reg} + CHARGE_MARGIN_MV)));
    assign source      = src_solar ? SRC_SOLAR : (src_battery ? SRC_BATTERY : SRC_NONE);
    assign total_add   = {1'b0, charge_total_reg} + (TOTAL_W + 1)'(step_reg);

    always_comb
    begin
        state_next        = state_reg;
        panel_gain_next   = panel_gain_reg;
        battery_gain_next = battery_gain_reg;
        full_next         = full_reg;
        empty_next        = empty_reg;
        low_next          = low_reg;
        solar_next        = solar_reg;
        step_next         = step_reg;
        pair_count_next   = pair_count_reg;
        panel_sum_next    = panel_sum_reg;
        battery_sum_next  = battery_sum_reg;
        charge_total_next = charge_total_reg;
        step_cnt_next     = step_cnt_reg;
        out_valid_next    = out_valid_reg;
        psum_op_next      = psum_op_reg;
        bsum_op_next      = bsum_op_reg;
        pmul_next         = pmul_reg;
        bmul_next         = bmul_reg;
        pmv_next          = pmv_reg;
        bmv_next          = bmv_reg;
        ge_full_next      = ge_full_reg;
        le_empty_next     = le_empty_reg;
        rem_next          = rem_reg;
        divisor_next      = divisor_reg;
        quot_next         = quot_reg;
        coef_next         = coef_reg;
        sq_next           = sq_reg;
        out_data_next     = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PANEL_GAIN:   panel_gain_next   = cfg_data;
                REG_BATTERY_GAIN: battery_gain_next = cfg_data;
                REG_FULL:         full_next         = cfg_data;
                REG_EMPTY:        empty_next        = cfg_data;
                REG_LOW:          low_next          = cfg_data;
                REG_SOLAR:        solar_next        = cfg_data;
                REG_STEP:         step_next         = cfg_data;
                default:          ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ({1'b0, pair_count_reg} == LAST_PAIR)
                    begin
                        pair_count_next  = '0;
                        panel_sum_next   = '0;
                        battery_sum_next = '0;
                        psum_op_next     = psum_add;
                        bsum_op_next     = bsum_add;
                        pmul_next        = MUL_W'(panel_gain_reg);
                        bmul_next        = MUL_W'(battery_gain_reg);
                        step_cnt_next    = '0;
                        state_next       = ST_MULT;
                    end
                    else
                    begin
                        pair_count_next  = pair_count_reg + 6'd1;
                        panel_sum_next   = psum_add;
                        battery_sum_next = bsum_add;
                    end
                end
            end
            ST_MULT:
            begin
                pmul_next     = {pmul_part, pmul_reg[CFG_W-1:1]};
                bmul_next     = {bmul_part, bmul_reg[CFG_W-1:1]};
                step_cnt_next = step_cnt_reg + 4'd1;
                if (step_cnt_reg == '1)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                pmv_next      = pmv_sat;
                bmv_next      = bmv_sat;
                ge_full_next  = bmv_sat >= full_reg;
                le_empty_next = bmv_sat <= empty_reg;
                rem_next      = bmv_sat - empty_reg;
                divisor_next  = full_reg - empty_reg;
                quot_next     = '0;
                step_cnt_next = '0;
                // The division is only needed strictly between empty and full.
                if ((bmv_sat >= full_reg) || (bmv_sat <= empty_reg))
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // The remainder stays below the divisor, so the shifted value fits 17 bits.
                if (rem_shift >= {1'b0, divisor_reg})
                begin
                    rem_next  = MV_W'(rem_shift - {1'b0, divisor_reg});
                    quot_next = {quot_reg[QX_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[MV_W-1:0];
                    quot_next = {quot_reg[QX_W-2:0], 1'b0};
                end
                step_cnt_next = step_cnt_reg + 4'd1;
                if (step_cnt_reg == '1)
                    state_next = ST_KPREP;
            end
            ST_KPREP:
            begin
                // pct = x * (130 * 2^16 - 30 * x) / 2^32
                coef_next     = K_BASE - quot_x30;
                sq_next       = SQ_W'(quot_reg);
                step_cnt_next = '0;
                state_next    = ST_SQ;
            end
            ST_SQ:
            begin
                sq_next       = {sq_part, sq_reg[QX_W-1:1]};
                step_cnt_next = step_cnt_reg + 4'd1;
                if (step_cnt_reg == '1)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.panel_mv       = pmv_reg;
                    out_data_next.battery_mv     = bmv_reg;
                    out_data_next.charge_percent = pct;
                    out_data_next.battery_low    = bmv_reg < low_reg;
                    out_data_next.power_source   = source;
                    out_data_next.charging       = charging;
                    out_data_next.charge_uah     = charge_total_reg;
                    if (charging && (bmv_reg < full_reg))
                    begin
                        charge_total_next = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
                        out_data_next.charge_uah = charge_total_next;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            panel_gain_reg   <= RST_PANEL_GAIN;
            battery_gain_reg <= RST_BATTERY_GAIN;
            full_reg         <= RST_FULL;
            empty_reg        <= RST_EMPTY;
            low_reg          <= RST_LOW;
            solar_reg        <= RST_SOLAR;
            step_reg         <= RST_STEP;
            pair_count_reg   <= '0;
            panel_sum_reg    <= '0;
            battery_sum_reg  <= '0;
            charge_total_reg <= '0;
            step_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            panel_gain_reg   <= panel_gain_next;
            battery_gain_reg <= battery_gain_next;
            full_reg         <= full_next;
            empty_reg        <= empty_next;
            low_reg          <= low_next;
            solar_reg        <= solar_next;
            step_reg         <= step_next;
            pair_count_reg   <= pair_count_next;
            panel_sum_reg    <= panel_sum_next;
            battery_sum_reg  <= battery_sum_next;
            charge_total_reg <= charge_total_next;
            step_cnt_reg     <= step_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        psum_op_reg  <= psum_op_next;
        bsum_op_reg  <= bsum_op_next;
        pmul_reg     <= pmul_next;
        bmul_reg     <= bmul_next;
        pmv_reg      <= pmv_next;
        bmv_reg      <= bmv_next;
        ge_full_reg  <= ge_full_next;
        le_empty_reg <= le_empty_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        quot_reg     <= quot_next;
        coef_reg     <= coef_next;
        sq_reg       <= sq_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
    import sbm_pkg::*;

    localparam int PAIRS_PER_READING = 16;
    localparam int NUM_REGS = 7;
    // Covers the longest reading sequence, with some margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_SUM = PAIRS_PER_READING * 4095;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef logic [CFG_W-1:0] reg_file_t [NUM_REGS];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int pairs_taken = 0;
    int readings_checked = 0;
    int reg_writes = 0;

    reg_file_t reset_regs = '{RST_PANEL_GAIN, RST_BATTERY_GAIN, RST_FULL, RST_EMPTY,
                              RST_LOW, RST_SOLAR, RST_STEP};

    // Shadow of the block: registers, sums and the charge total.
    reg_file_t            live_regs = '{RST_PANEL_GAIN, RST_BATTERY_GAIN, RST_FULL, RST_EMPTY,
                                        RST_LOW, RST_SOLAR, RST_STEP};
    logic [5:0]           pair_index = '0;
    logic [SUM_W-1:0]     panel_acc = '0;
    logic [SUM_W-1:0]     battery_acc = '0;
    logic [TOTAL_W-1:0]   charge_acc = '0;
    out_item_t            pending_readings [$];

    solar_battery_monitor #(
        .SAMPLES_PER_READING(PAIRS_PER_READING)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [MV_W-1:0] sum_to_mv(logic [SUM_W-1:0] sum, logic [CFG_W-1:0] gain);
        logic [SUM_W+CFG_W-1:0] product;
        product = (SUM_W+CFG_W)'(sum) * (SUM_W+CFG_W)'(gain);
        if (product[SUM_W+CFG_W-1:16] > 18'h0FFFF)
            return 16'hFFFF;
        return product[31:16];
    endfunction

    function automatic logic [PCT_W-1:0] soc_percent(logic [MV_W-1:0] v, full, empty);
        logic [63:0] x_q16;
        logic [63:0] fit;
        if (v >= full)
            return PCT_FULL;
        if (v <= empty)
            return PCT_EMPTY;
        x_q16 = (64'(v - empty) << 16) / 64'(full - empty);
        fit = (64'd130 * x_q16 * 64'd65536 - 64'd30 * x_q16 * x_q16) >> 32;
        if (fit > 64'd100)
            return PCT_FULL;
        return fit[PCT_W-1:0];
    endfunction

    function automatic void absorb_pair(in_item_t pair);
        out_item_t             r;
        logic [MV_W:0]         battery_plus_margin;
        logic [TOTAL_W:0]      grown;
        panel_acc = panel_acc + SUM_W'(pair.panel_sample);
        battery_acc = battery_acc + SUM_W'(pair.battery_sample);
        if (pair_index + 1 < PAIRS_PER_READING)
        begin
            pair_index = pair_index + 6'd1;
            return;
        end
        r.panel_mv = sum_to_mv(panel_acc, live_regs[REG_PANEL_GAIN]);
        r.battery_mv = sum_to_mv(battery_acc, live_regs[REG_BATTERY_GAIN]);
        pair_index = '0;
        panel_acc = '0;
        battery_acc = '0;
        r.charge_percent = soc_percent(r.battery_mv, live_regs[REG_FULL], live_regs[REG_EMPTY]);
        r.battery_low = (r.battery_mv < live_regs[REG_LOW]);
        battery_plus_margin = {1'b0, r.battery_mv} + CHARGE_MARGIN_MV;
        if (r.panel_mv > live_regs[REG_SOLAR])
        begin
            r.power_source = SRC_SOLAR;
            r.charging = 1'b1;
        end
        else if (r.battery_mv > live_regs[REG_EMPTY])
        begin
            r.power_source = SRC_BATTERY;
            r.charging = ({1'b0, r.panel_mv} > battery_plus_margin);
        end
        else
        begin
            r.power_source = SRC_NONE;
            r.charging = 1'b0;
        end
        if (r.charging && r.battery_mv < live_regs[REG_FULL])
        begin
            grown = {1'b0, charge_acc} + (TOTAL_W+1)'(live_regs[REG_STEP]);
            charge_acc = grown[TOTAL_W] ? '1 : grown[TOTAL_W-1:0];
        end
        r.charge_uah = charge_acc;
        pending_readings.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_reading(out_item_t want, out_item_t got);
        readings_checked++;
        check_field("panel_mv", 64'(want.panel_mv), 64'(got.panel_mv));
        check_field("battery_mv", 64'(want.battery_mv), 64'(got.battery_mv));
        check_field("charge_percent", 64'(want.charge_percent), 64'(got.charge_percent));
        check_field("battery_low", 64'(want.battery_low), 64'(got.battery_low));
        check_field("power_source", 64'(want.power_source), 64'(got.power_source));
        check_field("charging", 64'(want.charging), 64'(got.charging));
        check_field("charge_uah", 64'(want.charge_uah), 64'(got.charge_uah));
    endfunction

    // Results are checked before the pair of the same edge is absorbed: a reading
    // can never leave the block at the edge of its own final transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: %p", out_data);
                error_count++;
            end
            else
                check_reading(pending_readings.pop_front(), out_data);
        end
        if (rst_n && cfg_we && cfg_index < NUM_REGS)
            live_regs[cfg_index] = cfg_data;
        if (rst_n && in_valid && in_ready)
        begin
            pairs_taken++;
            absorb_pair(in_data);
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_pair(input logic [SAMPLE_W-1:0] panel, input logic [SAMPLE_W-1:0] battery);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= '{panel_sample: panel, battery_sample: battery};
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [SAMPLE_W-1:0] spread(int sum, int i, int jitter);
        int s;
        s = sum / PAIRS_PER_READING + ((i < sum % PAIRS_PER_READING) ? 1 : 0);
        if (jitter > 0)
            s = s + int'($urandom_range(2 * jitter)) - jitter;
        if (s < 0)
            s = 0;
        if (s > 4095)
            s = 4095;
        return s[SAMPLE_W-1:0];
    endfunction

    // Sends one reading's worth of pairs whose sums land on the given totals when jitter is zero.
    task automatic send_reading(input int panel_sum, input int battery_sum, input int jitter);
        for (int i = 0; i < PAIRS_PER_READING; i++)
            send_pair(spread(panel_sum, i, jitter), spread(battery_sum, i, jitter));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic write_registers(input reg_file_t vals);
        for (int i = 0; i < NUM_REGS; i++)
            write_register(i[CFG_IDX_W-1:0], vals[i]);
        cfg_we <= 1'b0;
    endtask

    function automatic int mv_to_sum(int mv, logic [CFG_W-1:0] gain);
        longint s;
        if (gain == 0)
            return $urandom_range(MAX_SUM);
        if (mv <= 0)
            return 0;
        s = (longint'(mv) * 65536 + gain - 1) / gain;
        return (s > MAX_SUM) ? MAX_SUM : int'(s);
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return CFG_W'($urandom_range(40000, 2000));
        endcase
    endfunction

    function automatic void random_regs(output reg_file_t r);
        int span;
        r[REG_PANEL_GAIN] = pick_gain();
        r[REG_BATTERY_GAIN] = pick_gain();
        r[REG_EMPTY] = CFG_W'($urandom_range(int'(r[REG_BATTERY_GAIN]) * 3 / 4));
        if ($urandom_range(7) == 0)
            r[REG_FULL] = CFG_W'($urandom_range(r[REG_EMPTY]));
        else
        begin
            span = r[REG_EMPTY] + $urandom_range(int'(r[REG_BATTERY_GAIN]) / 2 + 1, 1);
            r[REG_FULL] = (span > 65535) ? 16'hFFFF : span[CFG_W-1:0];
        end
        r[REG_LOW] = CFG_W'($urandom_range(r[REG_EMPTY], r[REG_FULL]));
        r[REG_SOLAR] = CFG_W'($urandom_range(r[REG_PANEL_GAIN]));
        case ($urandom_range(5))
            0: r[REG_STEP] = 16'd0;
            1: r[REG_STEP] = 16'hFFFF;
            default: r[REG_STEP] = CFG_W'($urandom_range(65535));
        endcase
    endfunction

    // Most readings are aimed at the thresholds of the current settings; the
    // rest are raw samples over the whole range.
    task automatic random_reading(input reg_file_t r);
        int lo;
        int bmv;
        int pmv;
        if ($urandom_range(9) < 2)
        begin
            repeat (PAIRS_PER_READING)
                send_pair(SAMPLE_W'($urandom_range(4095)), SAMPLE_W'($urandom_range(4095)));
            return;
        end
        lo = int'(r[REG_EMPTY]) - 100;
        if (lo < 0)
            lo = 0;
        bmv = $urandom_range(lo, int'(r[REG_FULL]) + 100);
        case ($urandom_range(3))
            0: pmv = bmv + 298 + $urandom_range(4);
            1: pmv = int'(r[REG_SOLAR]) - 2 + int'($urandom_range(4));
            default: pmv = $urandom_range(r[REG_PANEL_GAIN]);
        endcase
        send_reading(mv_to_sum(pmv, r[REG_PANEL_GAIN]), mv_to_sum(bmv, r[REG_BATTERY_GAIN]),
                     $urandom_range(2));
    endtask

    task automatic test_reset_defaults();
        set_idling(0, 0);
        send_reading(MAX_SUM, MAX_SUM, 0);
        send_reading(0, 0, 0);
        send_reading(16 * 2000, 16 * 2150, 0);
        drain();
    endtask

    task automatic test_register_extremes();
        reg_file_t r;
        r = '{default: '0};
        write_registers(r);
        send_reading(30000, 40000, 0);
        drain();
        r = '{default: '1};
        write_registers(r);
        send_reading(MAX_SUM, MAX_SUM, 0);
        send_reading(0, 0, 0);
        drain();
    endtask

    // With a gain of 65535 a sum of s gives s - 1 millivolts, so the edges of
    // the charge curve can be hit exactly.
    task automatic test_charge_curve();
        reg_file_t r;
        r = reset_regs;
        r[REG_PANEL_GAIN] = 16'hFFFF;
        r[REG_BATTERY_GAIN] = 16'hFFFF;
        r[REG_FULL] = 16'd4000;
        r[REG_EMPTY] = 16'd1000;
        r[REG_LOW] = 16'd2000;
        r[REG_SOLAR] = 16'hFFFF;
        r[REG_STEP] = 16'd100;
        write_registers(r);
        send_reading(0, 1001, 0);
        send_reading(0, 1002, 0);
        send_reading(0, 2000, 0);
        send_reading(0, 2001, 0);
        send_reading(0, 2501, 0);
        send_reading(0, 4000, 0);
        send_reading(0, 4001, 0);
        drain();
        // Full set at or below empty: only the clamps decide.
        write_register(REG_FULL, 16'd900);
        cfg_we <= 1'b0;
        send_reading(0, 1000, 0);
        send_reading(0, 801, 0);
        drain();
    endtask

    task automatic test_source_rules();
        reg_file_t r;
        r = reset_regs;
        r[REG_PANEL_GAIN] = 16'hFFFF;
        r[REG_BATTERY_GAIN] = 16'hFFFF;
        r[REG_FULL] = 16'd4000;
        r[REG_EMPTY] = 16'd1000;
        r[REG_LOW] = 16'd2000;
        r[REG_SOLAR] = 16'd5000;
        r[REG_STEP] = 16'hFFFF;
        write_registers(r);
        send_reading(5002, 2001, 0);
        send_reading(5001, 2001, 0);
        send_reading(2301, 2001, 0);
        send_reading(2302, 2001, 0);
        send_reading(6000, 4501, 0);
        send_reading(3000, 1001, 0);
        drain();
    endtask

    task automatic test_unknown_register();
        write_registers(reset_regs);
        write_register(REG_UNUSED, 16'h0001);
        cfg_we <= 1'b0;
        send_reading(16 * 2400, 16 * 2100, 0);
        drain();
    endtask

    task automatic test_random_traffic();
        reg_file_t r;
        int readings;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(75, 0);
                2: set_idling(0, 75);
                default: set_idling(25, 25);
            endcase
            random_regs(r);
            write_registers(r);
            readings = $urandom_range(14, 11);
            repeat (readings) random_reading(r);
            drain();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_charge_curve();
        test_source_rules();
        test_unknown_register();
        test_random_traffic();
        $display("Checked %0d readings built from %0d sample pairs, with %0d register writes.",
                 readings_checked, pairs_taken, reg_writes);
        $display("Settings covered defaults, both register extremes and random thresholds.");
        if (error_count == 0)
            $display("solar_battery_monitor regression: pass");
        else
            $display("solar_battery_monitor regression: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("solar_battery_monitor regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/sbm_pkg.sv
rtl/solar_battery_monitor.sv
tb/tb.sv
